// ===== design/tac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tac_pkg;

  // field widths
  localparam int CMD_W        = 1;
  localparam int INTERVAL_W   = 24;
  localparam int RPM_W        = 26;
  localparam int PPR_W        = 7;
  localparam int TICK_W       = 10;
  localparam int DECAY_W      = 8;
  localparam int AGE_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int PROD_W       = INTERVAL_W + PPR_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PPR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

  // register reset values
  localparam logic [PPR_W-1:0]   PPR_RESET   = 7'd1;
  localparam logic [TICK_W-1:0]  TICK_RESET  = 10'd10;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd230;

  // arithmetic constants
  localparam logic [RPM_W-1:0]  RPM_NUMERATOR = 26'd60000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_AVG,
    OP_STALE
  } op_t;

endpackage

`default_nettype wire

// ===== design/tac_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tac_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/tac_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tac_div #(
  parameter int DW = 31,
  parameter int VW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

  logic [DW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[DW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== design/tachometer_rpm_average_decay_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// tachometer with moving-average speed and stale-speed decay
// input channel (in_valid/in_ready): a beat is either an interval sample
//   (cmd 0, pulse_gap_us between hall pulses) or a periodic tick (cmd 1)
// output channel (out_valid/out_ready): one beat of rpm/decayed per tick that
//   reports; a sample never produces an output beat
// config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   0 pulses per rev, 1 tick period in ms, 2 decay factor in 1/256
// sequence: a sample or an averaging tick goes from its accept through the
//   multiply state, an operand load state, the bit-serial divider and the
//   finish state before the next accept, the divider setting the pace; a
//   stale-check tick skips the divider, and a zero-interval sample is dropped
//   at its accept
// throughput: one item at a time, in_ready is high only between items
// the window lives in a WINDOW-entry ram; the entry being replaced is read
//   while the divider runs and written back in the finish cycle
// reset (rst, synchronous): registers back to defaults, window empty, speed
//   and age zero; no clearing pass, unwritten entries are never used
// output stall: the result waits in the output register; a later reporting
//   tick holds in its finish cycle until that register is taken
module tachometer_rpm_average_decay_unit #(
  parameter int WINDOW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [tac_pkg::INTERVAL_W-1:0]    pulse_gap_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tac_pkg::RPM_W-1:0]         rpm,
  output logic                              decayed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import tac_pkg::*;

  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SUMW = RPM_W + $clog2(WINDOW);
  localparam int DW   = (SUMW > PROD_W) ? SUMW : PROD_W;

  // config registers
  logic [PPR_W-1:0]      ppr;
  logic [TICK_W-1:0]     tick_period;
  logic [DECAY_W-1:0]    decay_factor;

  // control
  state_t                state, state_next;
  op_t                   op;
  logic                  in_accept;
  logic                  div_start;
  logic                  div_done;
  logic                  out_load;
  logic                  out_free;
  logic                  ram_we;

  // datapath
  logic [INTERVAL_W-1:0] mul_a;
  logic [PPR_W-1:0]      ppr_eff;
  logic [PROD_W-1:0]     prod;
  logic [DW-1:0]         div_dividend;
  logic [PROD_W-1:0]     div_divisor;
  logic [DW-1:0]         div_quot;
  logic [RPM_W-1:0]      quot_rpm;
  logic [RPM_W-1:0]      ram_rdata;

  // tracked state
  logic [AW-1:0]         window_ptr;
  logic [CW-1:0]         window_count;
  logic [SUMW-1:0]       window_sum;
  logic [SUMW-1:0]       window_sum_next;
  logic                  window_full;
  logic                  sample_seen;
  logic [INTERVAL_W-1:0] last_interval;
  logic [RPM_W-1:0]      held_rpm;
  logic [AGE_W-1:0]      signal_age;
  logic [AGE_W:0]        age_sum;
  logic [AGE_W-1:0]      age_sat;
  logic [AGE_W+9:0]      age_us;
  logic                  stale_hit;
  logic [RPM_W+DECAY_W-1:0] decay_prod;
  logic [RPM_W-1:0]      decay_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // zero pulses per rev counts as one
  assign ppr_eff = (ppr == '0) ? PPR_W'(1) : ppr;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ppr          <= PPR_RESET;
      tick_period  <= TICK_RESET;
      decay_factor <= DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PPR:   ppr          <= cfg_data[PPR_W-1:0];
        REG_TICK:  tick_period  <= cfg_data[TICK_W-1:0];
        REG_DECAY: decay_factor <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        // a zero interval is taken and dropped
        if (in_valid && (cmd == CMD_TICK || pulse_gap_us != '0)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        // the stale check needs no division, straight to the finish
        if (op == OP_STALE) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        case (op)
          OP_SAMPLE: begin
            ram_we     = 1'b1;
            state_next = ST_IDLE;
          end
          OP_AVG: begin
            if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_STALE: begin
            if (!stale_hit) begin
              state_next = ST_IDLE;
            end else if (out_free) begin
              out_load   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // latch the item: samples multiply their own interval, stale ticks the last one
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mul_a <= (cmd == CMD_SAMPLE) ? pulse_gap_us : last_interval;
      if (cmd == CMD_SAMPLE) begin
        op <= OP_SAMPLE;
      end else if (sample_seen) begin
        op <= OP_AVG;
      end else begin
        op <= OP_STALE;
      end
    end
  end

  // saturating age after this tick
  assign age_sum = {1'b0, signal_age} + (AGE_W + 1)'(tick_period);
  assign age_sat = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];

  // interval times pulses per rev, and the new age in us (1000 = 1024 - 16 - 8),
  // both registered ahead of use
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod   <= PROD_W'(mul_a) * PROD_W'(ppr_eff);
      age_us <= {age_sat, 10'd0} - {6'd0, age_sat, 4'd0} - {7'd0, age_sat, 3'd0};
    end
  end

  // one shared divider: rpm from period, window average
  always_comb begin
    case (op)
      OP_AVG: begin
        div_dividend = DW'(window_sum);
        div_divisor  = PROD_W'(window_count);
      end
      default: begin
        div_dividend = DW'(RPM_NUMERATOR);
        div_divisor  = prod;
      end
    endcase
  end

  tac_div #(
    .DW (DW),
    .VW (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign quot_rpm = div_quot[RPM_W-1:0];

  // window ram: the slot at window_ptr is read every cycle, so the entry
  // being replaced is on ram_rdata by the finish cycle
  tac_ram #(
    .WIDTH (RPM_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_ptr),
    .wdata (quot_rpm),
    .raddr (window_ptr),
    .rdata (ram_rdata)
  );

  // running sum drops the oldest entry once the window is full
  assign window_full     = (window_count == CW'(WINDOW));
  assign window_sum_next = window_sum - (window_full ? SUMW'(ram_rdata) : '0)
                           + SUMW'(quot_rpm);

  // stale once the age passes one rotation period: age > prod / 1000 in ms
  // is the same as prod < age * 1000
  assign stale_hit = {11'd0, prod} < age_us;

  // q8 decay of the held speed
  assign decay_prod = (RPM_W + DECAY_W)'(held_rpm) * (RPM_W + DECAY_W)'(decay_factor);
  assign decay_val  = decay_prod[RPM_W+DECAY_W-1:DECAY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ptr    <= '0;
      window_count  <= '0;
      window_sum    <= '0;
      sample_seen   <= 1'b0;
      last_interval <= '0;
      held_rpm      <= '0;
      signal_age    <= '0;
    end else if (state == ST_FIN) begin
      case (op)
        OP_SAMPLE: begin
          window_sum    <= window_sum_next;
          window_ptr    <= (window_ptr == AW'(WINDOW - 1)) ? '0 : window_ptr + 1'b1;
          if (!window_full) begin
            window_count <= window_count + 1'b1;
          end
          last_interval <= mul_a;
          sample_seen   <= 1'b1;
        end
        OP_AVG: begin
          if (out_free) begin
            held_rpm    <= quot_rpm;
            signal_age  <= '0;
            sample_seen <= 1'b0;
          end
        end
        OP_STALE: begin
          if (!stale_hit) begin
            signal_age <= age_sat;
          end else if (out_free) begin
            held_rpm   <= decay_val;
            signal_age <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rpm     <= (op == OP_AVG) ? quot_rpm : decay_val;
      decayed <= (op == OP_STALE);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    window_count <= CW'(WINDOW))
    else $error("window count past window size");

  a_seen_has_data: assert property (@(posedge clk) disable iff (rst)
    sample_seen |-> window_count != '0)
    else $error("sample flagged with empty window");

  a_decay_shrinks: assert property (@(posedge clk) disable iff (rst)
    (out_load && op == OP_STALE) |=> rpm <= $past(held_rpm))
    else $error("decayed speed above held speed");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
